### design/ccr_pkg.sv
// shared types, codes and width helpers of the circle canvas rasterizer
package ccr_pkg;

    // default sizes
    localparam int DEF_MAX_DIM   = 256;
    localparam int DEF_FRAC_BITS = 8;

    // fixed field widths
    localparam int CFG_W   = 9;
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 24;
    localparam int RDIDX_W = 8;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_RADIUS = 2'd1;
    localparam logic [1:0] STAT_BAD_KIND   = 2'd2;

    // shape kinds
    localparam logic [7:0] KIND_OUTLINE = 8'h63;
    localparam logic [7:0] KIND_FILLED  = 8'h43;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    // reset value of the background byte
    localparam logic [7:0] BG_RESET = 8'd32;

    // bits of a row or column index
    function automatic int idx_bits(input int max_dim);
        return (max_dim > 1) ? $clog2(max_dim) : 1;
    endfunction

    // bits of a counter that can hold max_dim itself
    function automatic int dim_bits(input int max_dim);
        return $clog2(max_dim + 1);
    endfunction

    // bits of a signed coordinate difference
    function automatic int diff_bits(input int max_dim, input int frac_bits);
        int pos_w;
        pos_w = idx_bits(max_dim) + frac_bits;
        return ((pos_w > COORD_W - 1) ? pos_w : COORD_W - 1) + 2;
    endfunction

    // what a squared operand is used for
    typedef enum logic [1:0] {
        TAG_R2,
        TAG_INNER,
        TAG_DY,
        TAG_PIX
    } t_tag;

    // one beat into the squaring pipeline
    typedef struct packed {
        logic vld;
        t_tag tag;
    } t_issue;

    // drawing mode held for the whole sweep
    typedef struct packed {
        logic              thin;
        logic              filled;
        logic [CHAR_W-1:0] paint;
    } t_mode;

    // one finished result
    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] pixel;
    } t_result;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SQ_R,
        S_SQ_IN,
        S_ROW,
        S_COL,
        S_DRAIN,
        S_READ,
        S_RDATA,
        S_DONE
    } t_state;

endpackage

### design/circle_canvas_rasterizer_unit.sv
// top level of the circle canvas rasterizer
//
// Input channel: one beat carries a command (clear, draw circle, read pixel)
// with its fields; it is taken when i_in_valid is high and o_in_stall low.
// Output channel: exactly one beat per command with a status and a pixel
// byte; it is taken when o_out_valid is high and i_out_stall low.
// Configuration: i_cfg_we writes canvas width (0), height (1) or the
// background byte (2) at i_cfg_idx; write only while the block is idle.
// Work per command:
//   clear: writes the background byte to the whole store, one byte a cycle
//   draw:  one pixel a cycle plus one row setup step each row, through a
//          two stage squaring pipeline; no pixels if w or h is 0
//   read:  one store read, none outside the canvas; errors and others: none
// The next command is taken as soon as the previous one has placed its
// result in the output register, even while that result still waits.
// A stalled result holds its beat; a new result waits in the sequencer.
// Reset clears control state and the registers (width 0, height 0,
// background space); the canvas is undefined until the first clear.
module circle_canvas_rasterizer_unit #(
    parameter int MAX_DIM   = ccr_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = ccr_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [ccr_pkg::CFG_W-1:0]           i_cfg_data,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_command,
    input  logic [7:0]                          i_shape_kind,
    input  logic signed [ccr_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [ccr_pkg::COORD_W-1:0]  i_center_y,
    input  logic signed [ccr_pkg::COORD_W-1:0]  i_radius,
    input  logic [ccr_pkg::CHAR_W-1:0]          i_paint_char,
    input  logic [ccr_pkg::RDIDX_W-1:0]         i_read_col,
    input  logic [ccr_pkg::RDIDX_W-1:0]         i_read_row,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [ccr_pkg::CHAR_W-1:0]          o_pixel_char
);
    localparam int IDX_W  = ccr_pkg::idx_bits(MAX_DIM);
    localparam int DIM_W  = ccr_pkg::dim_bits(MAX_DIM);
    localparam int D_W    = ccr_pkg::diff_bits(MAX_DIM, FRAC_BITS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CMP_W  = (DIM_W > ccr_pkg::CFG_W) ? DIM_W : ccr_pkg::CFG_W;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(MAX_DIM);

    logic [ccr_pkg::CFG_W-1:0]  r_cfg_w;
    logic [ccr_pkg::CFG_W-1:0]  r_cfg_h;
    logic [ccr_pkg::CHAR_W-1:0] r_bg;
    logic [DIM_W-1:0]           use_w;
    logic [DIM_W-1:0]           use_h;
    logic [CMP_W-1:0]           cw_ext;
    logic [CMP_W-1:0]           ch_ext;

    logic                       r_out_vld;
    ccr_pkg::t_result           r_out;

    ccr_pkg::t_issue            iss;
    logic signed [D_W-1:0]      op;
    logic [ADDR_W-1:0]          iss_addr;
    ccr_pkg::t_mode             mode;
    logic                       clr_we;
    logic [ADDR_W-1:0]          clr_addr;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ccr_pkg::CHAR_W-1:0] rdata;
    logic                       fin_vld;
    ccr_pkg::t_result           fin;
    logic                       fin_take;
    logic                       pipe_busy;
    logic                       pix_we;
    logic [ADDR_W-1:0]          pix_addr;
    logic [ccr_pkg::CHAR_W-1:0] pix_data;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ccr_pkg::CHAR_W-1:0] mem_wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= '0;
            r_cfg_h <= '0;
            r_bg    <= ccr_pkg::BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ccr_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                ccr_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                ccr_pkg::CFG_BG:     r_bg    <= i_cfg_data[ccr_pkg::CHAR_W-1:0];
                default:             ;
            endcase
        end
    end

    // canvas size in use, saturated to the store
    always_comb begin
        cw_ext = CMP_W'(r_cfg_w);
        ch_ext = CMP_W'(r_cfg_h);
        use_w  = DIM_W'((cw_ext > DIM_MAX) ? DIM_MAX : cw_ext);
        use_h  = DIM_W'((ch_ext > DIM_MAX) ? DIM_MAX : ch_ext);
    end

    ccr_ctrl #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_shape_kind (i_shape_kind),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_paint_char (i_paint_char),
        .i_read_col   (i_read_col),
        .i_read_row   (i_read_row),
        .i_width      (use_w),
        .i_height     (use_h),
        .i_rdata      (rdata),
        .i_pipe_busy  (pipe_busy),
        .i_fin_take   (fin_take),
        .o_iss        (iss),
        .o_op         (op),
        .o_iss_addr   (iss_addr),
        .o_mode       (mode),
        .o_clr_we     (clr_we),
        .o_clr_addr   (clr_addr),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_fin_vld    (fin_vld),
        .o_fin        (fin)
    );

    ccr_raster_pipe #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .i_op    (op),
        .i_addr  (iss_addr),
        .i_mode  (mode),
        .o_busy  (pipe_busy),
        .o_we    (pix_we),
        .o_waddr (pix_addr),
        .o_wdata (pix_data)
    );

    // clear sweep and pixel writes never overlap
    always_comb begin
        mem_we    = clr_we || pix_we;
        mem_waddr = clr_we ? clr_addr : pix_addr;
        mem_wdata = clr_we ? r_bg : pix_data;
    end

    ccr_canvas_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // output register
    assign fin_take = fin_vld && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_out <= fin;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out.status;
    assign o_pixel_char = r_out.pixel;
endmodule

### design/ccr_canvas_mem.sv
// canvas byte store, one write port and one registered read port
module ccr_canvas_mem #(
    parameter int MAX_DIM = ccr_pkg::DEF_MAX_DIM
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0] i_waddr,
    input  logic [ccr_pkg::CHAR_W-1:0]             i_wdata,
    input  logic                                   i_re,
    input  logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0] i_raddr,
    output logic [ccr_pkg::CHAR_W-1:0]             o_rdata
);
    localparam int ADDR_W = 2 * ccr_pkg::idx_bits(MAX_DIM);
    localparam int DEPTH  = 1 << ADDR_W;

    logic [ccr_pkg::CHAR_W-1:0] r_mem [0:DEPTH-1];
    logic [ccr_pkg::CHAR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/ccr_raster_pipe.sv
// squaring pipeline and pixel coverage test
module ccr_raster_pipe #(
    parameter int MAX_DIM   = ccr_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = ccr_pkg::DEF_FRAC_BITS
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  ccr_pkg::t_issue                                        i_iss,
    input  logic signed [ccr_pkg::diff_bits(MAX_DIM, FRAC_BITS)-1:0] i_op,
    input  logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0]                i_addr,
    input  ccr_pkg::t_mode                                         i_mode,
    output logic                                                   o_busy,
    output logic                                                   o_we,
    output logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0]                o_waddr,
    output logic [ccr_pkg::CHAR_W-1:0]                             o_wdata
);
    localparam int D_W    = ccr_pkg::diff_bits(MAX_DIM, FRAC_BITS);
    localparam int SQ_W   = 2 * D_W;
    localparam int ADDR_W = 2 * ccr_pkg::idx_bits(MAX_DIM);

    // stage 1: operand
    ccr_pkg::t_issue        r_t1;
    logic signed [D_W-1:0]  r_op;
    logic [ADDR_W-1:0]      r_a1;
    // stage 2: square
    ccr_pkg::t_issue        r_t2;
    logic [SQ_W-1:0]        r_sq;
    logic [ADDR_W-1:0]      r_a2;
    // held squares
    logic [SQ_W-1:0]        r_r2;
    logic [SQ_W-1:0]        r_inner2;
    logic [SQ_W-1:0]        r_dy2;

    logic signed [SQ_W-1:0] sq_full;
    logic [SQ_W-1:0]        d2;
    logic                   covered;
    logic                   ring;
    logic                   hit;

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t1 <= i_iss;
            r_t2 <= r_t1;
        end
    end

    assign sq_full = r_op * r_op;

    // operand and square registers
    always_ff @(posedge i_clk) begin
        r_op <= i_op;
        r_a1 <= i_addr;
        r_sq <= $unsigned(sq_full);
        r_a2 <= r_a1;
    end

    // keep the squares needed by later pixels
    always_ff @(posedge i_clk) begin
        if (r_t2.vld) begin
            unique case (r_t2.tag)
                ccr_pkg::TAG_R2:    r_r2     <= r_sq;
                ccr_pkg::TAG_INNER: r_inner2 <= r_sq;
                ccr_pkg::TAG_DY:    r_dy2    <= r_sq;
                default:            ;
            endcase
        end
    end

    // coverage test on the squared distance
    always_comb begin
        d2      = r_sq + r_dy2;
        covered = (d2 <= r_r2);
        ring    = covered && (i_mode.thin || (d2 > r_inner2));
        hit     = i_mode.filled ? covered : ring;
    end

    assign o_we    = r_t2.vld && (r_t2.tag == ccr_pkg::TAG_PIX) && hit;
    assign o_waddr = r_a2;
    assign o_wdata = i_mode.paint;
    assign o_busy  = r_t1.vld || r_t2.vld;
endmodule

### design/ccr_ctrl.sv
// command sequencer: clear sweep, draw sweep and pixel read
module ccr_ctrl #(
    parameter int MAX_DIM   = ccr_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = ccr_pkg::DEF_FRAC_BITS
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_in_valid,
    output logic                                                   o_in_stall,
    input  logic [1:0]                                             i_command,
    input  logic [7:0]                                             i_shape_kind,
    input  logic signed [ccr_pkg::COORD_W-1:0]                     i_center_x,
    input  logic signed [ccr_pkg::COORD_W-1:0]                     i_center_y,
    input  logic signed [ccr_pkg::COORD_W-1:0]                     i_radius,
    input  logic [ccr_pkg::CHAR_W-1:0]                             i_paint_char,
    input  logic [ccr_pkg::RDIDX_W-1:0]                            i_read_col,
    input  logic [ccr_pkg::RDIDX_W-1:0]                            i_read_row,
    input  logic [ccr_pkg::dim_bits(MAX_DIM)-1:0]                  i_width,
    input  logic [ccr_pkg::dim_bits(MAX_DIM)-1:0]                  i_height,
    input  logic [ccr_pkg::CHAR_W-1:0]                             i_rdata,
    input  logic                                                   i_pipe_busy,
    input  logic                                                   i_fin_take,
    output ccr_pkg::t_issue                                        o_iss,
    output logic signed [ccr_pkg::diff_bits(MAX_DIM, FRAC_BITS)-1:0] o_op,
    output logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0]                o_iss_addr,
    output ccr_pkg::t_mode                                         o_mode,
    output logic                                                   o_clr_we,
    output logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0]                o_clr_addr,
    output logic                                                   o_rd_en,
    output logic [2*ccr_pkg::idx_bits(MAX_DIM)-1:0]                o_rd_addr,
    output logic                                                   o_fin_vld,
    output ccr_pkg::t_result                                       o_fin
);
    localparam int IDX_W  = ccr_pkg::idx_bits(MAX_DIM);
    localparam int DIM_W  = ccr_pkg::dim_bits(MAX_DIM);
    localparam int D_W    = ccr_pkg::diff_bits(MAX_DIM, FRAC_BITS);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CMP_W  = (DIM_W > ccr_pkg::CFG_W) ? DIM_W : ccr_pkg::CFG_W;
    localparam int RD_W   = (IDX_W > ccr_pkg::RDIDX_W) ? IDX_W : ccr_pkg::RDIDX_W;
    localparam logic signed [D_W-1:0] ONE = D_W'(1) << FRAC_BITS;

    ccr_pkg::t_state                   r_state, n_state;
    logic [ADDR_W-1:0]                 r_clr, n_clr;
    logic [DIM_W-1:0]                  r_row, n_row;
    logic [DIM_W-1:0]                  r_col, n_col;
    logic signed [D_W-1:0]             r_cx, n_cx;
    logic signed [D_W-1:0]             r_cy, n_cy;
    logic signed [D_W-1:0]             r_rad, n_rad;
    ccr_pkg::t_mode                    r_mode, n_mode;
    logic [ADDR_W-1:0]                 r_rd_addr, n_rd_addr;
    ccr_pkg::t_result                  r_res, n_res;

    logic signed [D_W-1:0]             rad_in;
    logic                              rd_hit;
    logic [RD_W-1:0]                   rc_ext;
    logic [RD_W-1:0]                   rr_ext;
    logic [IDX_W-1:0]                  row_idx;
    logic [IDX_W-1:0]                  col_idx;
    logic [DIM_W-1:0]                  row_nxt;
    logic [DIM_W-1:0]                  col_nxt;

    // control and held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_clr     <= n_clr;
        r_row     <= n_row;
        r_col     <= n_col;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rad     <= n_rad;
        r_mode    <= n_mode;
        r_rd_addr <= n_rd_addr;
        r_res     <= n_res;
    end

    // helpers
    always_comb begin
        rad_in  = D_W'(i_radius);
        rc_ext  = RD_W'(i_read_col);
        rr_ext  = RD_W'(i_read_row);
        rd_hit  = (CMP_W'(i_read_col) < CMP_W'(i_width)) &&
                  (CMP_W'(i_read_row) < CMP_W'(i_height));
        row_idx = r_row[IDX_W-1:0];
        col_idx = r_col[IDX_W-1:0];
        row_nxt = r_row + DIM_W'(1);
        col_nxt = r_col + DIM_W'(1);
    end

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_row      = r_row;
        n_col      = r_col;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_rad      = r_rad;
        n_mode     = r_mode;
        n_rd_addr  = r_rd_addr;
        n_res      = r_res;
        o_iss      = '0;
        o_op       = '0;
        o_iss_addr = {row_idx, col_idx};
        o_clr_we   = 1'b0;
        o_rd_en    = 1'b0;
        o_fin_vld  = 1'b0;

        unique case (r_state)
            ccr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res          = '0;
                    n_cx           = D_W'(i_center_x);
                    n_cy           = D_W'(i_center_y);
                    n_rad          = rad_in;
                    n_mode.paint   = i_paint_char;
                    n_mode.filled  = (i_shape_kind == ccr_pkg::KIND_FILLED);
                    n_mode.thin    = (rad_in < ONE);
                    n_rd_addr      = {rr_ext[IDX_W-1:0], rc_ext[IDX_W-1:0]};
                    n_clr          = '0;
                    unique case (i_command)
                        ccr_pkg::CMD_CLEAR: begin
                            n_state = ccr_pkg::S_CLEAR;
                        end
                        ccr_pkg::CMD_DRAW: begin
                            if (i_radius <= 0) begin
                                n_res.status = ccr_pkg::STAT_BAD_RADIUS;
                                n_state      = ccr_pkg::S_DONE;
                            end else if (i_shape_kind != ccr_pkg::KIND_OUTLINE &&
                                         i_shape_kind != ccr_pkg::KIND_FILLED) begin
                                n_res.status = ccr_pkg::STAT_BAD_KIND;
                                n_state      = ccr_pkg::S_DONE;
                            end else begin
                                n_state = ccr_pkg::S_SQ_R;
                            end
                        end
                        ccr_pkg::CMD_READ: begin
                            n_state = rd_hit ? ccr_pkg::S_READ : ccr_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ccr_pkg::S_DONE;
                        end
                    endcase
                end
            end
            // fill the whole store, one byte a cycle
            ccr_pkg::S_CLEAR: begin
                o_clr_we = 1'b1;
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == {ADDR_W{1'b1}}) begin
                    n_state = ccr_pkg::S_DONE;
                end
            end
            ccr_pkg::S_SQ_R: begin
                o_iss.vld = 1'b1;
                o_iss.tag = ccr_pkg::TAG_R2;
                o_op      = r_rad;
                n_state   = ccr_pkg::S_SQ_IN;
            end
            ccr_pkg::S_SQ_IN: begin
                o_iss.vld = 1'b1;
                o_iss.tag = ccr_pkg::TAG_INNER;
                o_op      = r_rad - ONE;
                n_row     = '0;
                n_col     = '0;
                if (i_width == '0 || i_height == '0) begin
                    n_state = ccr_pkg::S_DRAIN;
                end else begin
                    n_state = ccr_pkg::S_ROW;
                end
            end
            // row distance, squared once per row
            ccr_pkg::S_ROW: begin
                o_iss.vld = 1'b1;
                o_iss.tag = ccr_pkg::TAG_DY;
                o_op      = $signed(D_W'(row_idx) << FRAC_BITS) - r_cy;
                n_col     = '0;
                n_state   = ccr_pkg::S_COL;
            end
            // one pixel of the row a cycle
            ccr_pkg::S_COL: begin
                o_iss.vld = 1'b1;
                o_iss.tag = ccr_pkg::TAG_PIX;
                o_op      = $signed(D_W'(col_idx) << FRAC_BITS) - r_cx;
                if (col_nxt == i_width) begin
                    if (row_nxt == i_height) begin
                        n_state = ccr_pkg::S_DRAIN;
                    end else begin
                        n_row   = row_nxt;
                        n_state = ccr_pkg::S_ROW;
                    end
                end else begin
                    n_col = col_nxt;
                end
            end
            ccr_pkg::S_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_state = ccr_pkg::S_DONE;
                end
            end
            ccr_pkg::S_READ: begin
                o_rd_en = 1'b1;
                n_state = ccr_pkg::S_RDATA;
            end
            ccr_pkg::S_RDATA: begin
                n_res.pixel = i_rdata;
                n_state     = ccr_pkg::S_DONE;
            end
            ccr_pkg::S_DONE: begin
                o_fin_vld = 1'b1;
                if (i_fin_take) begin
                    n_state = ccr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ccr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ccr_pkg::S_IDLE);
    assign o_mode     = r_mode;
    assign o_clr_addr = r_clr;
    assign o_rd_addr  = r_rd_addr;
    assign o_fin      = r_res;
endmodule
